### design/assert_macros.svh
// Assertion macros shared by the checker of the swap slot allocator.
// Needs a clk and an active-low rst_n in the scope that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, silent while reset is held
`define SSA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property, checked during reset as well
`define SSA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/ssa_pkg.sv
// Shared types and constants of the swap slot allocator.
// Used by ssa_ctrl, ssa_dpath and the top level; depends on nothing.
package ssa_pkg;

  localparam int WORD_W      = 16;
  localparam int BIT_W       = 4;
  localparam int CFG_AREAS   = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 11;
  localparam int TAG_W       = 8;
  localparam int OFF_IN_W    = 24;
  localparam int OFF_OUT_W   = 10;
  localparam int TOTAL_OUT_W = 13;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 40;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NO_SPACE     = 2'd1,
    ST_NOT_FOUND    = 2'd2,
    ST_ALREADY_FREE = 2'd3
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic clr;       // zero one bitmap word of the clearing pass
    logic accept;    // latch request, pick area and bounds
    logic rd;        // read bitmap word at current address
    logic step;      // move to next word and read it
    logic commit;    // write back flipped bit, update counts
    logic reject;    // no area / out of range
    logic free_miss; // slot already free
    logic load_out;  // move result into output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic is_free;
    logic found;
    logic hit;
    logic out_free;
  } sts_t;

endpackage

### design/ssa_ctrl.sv
// Controller of the swap slot allocator: sequences clear, search and commit.
// Depends on ssa_pkg.
module ssa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  ssa_pkg::sts_t sts,
  output ssa_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PLAN,
    S_CHK,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_PLAN;
        end
      end
      S_PLAN: begin
        if (sts.found) begin
          cmd.rd    = 1'b1;
          state_nxt = S_CHK;
        end else begin
          cmd.reject = 1'b1;
          state_nxt  = S_FIN;
        end
      end
      S_CHK: begin
        if (sts.hit) begin
          cmd.commit = 1'b1;
          state_nxt  = S_FIN;
        end else if (sts.is_free) begin
          cmd.free_miss = 1'b1;
          state_nxt     = S_FIN;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### design/ssa_dpath.sv
// Datapath of the swap slot allocator: config registers, counts, bitmap
// memory, area selection, word search and output register. Depends on ssa_pkg.
module ssa_dpath #(
  parameter int NUM_AREAS      = 4,
  parameter int SLOTS_PER_AREA = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ssa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ssa_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                in_action,
  input  logic [ssa_pkg::TAG_W-1:0]           in_tag,
  input  logic [ssa_pkg::OFF_IN_W-1:0]        in_offset,
  input  ssa_pkg::cmd_t                       cmd,
  output ssa_pkg::sts_t                       sts,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ssa_pkg::OUT_DATA_W-1:0]      out_tdata
);

  localparam int TOTAL_SLOTS = NUM_AREAS * SLOTS_PER_AREA;
  localparam int NWORDS  = (TOTAL_SLOTS + ssa_pkg::WORD_W - 1) / ssa_pkg::WORD_W;
  localparam int AW      = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int IW      = AW + ssa_pkg::BIT_W;
  localparam int ARW     = (NUM_AREAS > 1) ? $clog2(NUM_AREAS) : 1;
  localparam int CNT_W   = $clog2(SLOTS_PER_AREA + 1);
  localparam int TOT_W   = $clog2(TOTAL_SLOTS + 1);
  localparam int MEM_D   = 1 << AW;
  localparam int WB      = ssa_pkg::WORD_W;
  localparam int BW      = ssa_pkg::BIT_W;
  localparam int TW      = ssa_pkg::TAG_W;

  // Configuration registers
  logic [ssa_pkg::CFG_DATA_W-1:0] cfg_slots_r [ssa_pkg::CFG_AREAS];
  logic [TW-1:0]                  cfg_tag_r   [ssa_pkg::CFG_AREAS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ssa_pkg::CFG_AREAS; i++) begin
        cfg_slots_r[i] <= '0;
        cfg_tag_r[i]   <= TW'(i);
      end
    end else if (cfg_we) begin
      if (cfg_index < ssa_pkg::CFG_IDX_W'(ssa_pkg::CFG_AREAS)) begin
        cfg_slots_r[cfg_index[1:0]] <= cfg_wdata;
      end else begin
        cfg_tag_r[cfg_index[1:0]] <= cfg_wdata[TW-1:0];
      end
    end
  end

  // Per-area usable size and tag; areas past the configurable ones are empty
  logic [CNT_W-1:0] usable [NUM_AREAS];
  logic [TW-1:0]    tagv   [NUM_AREAS];
  logic [CNT_W-1:0] cnt_r  [NUM_AREAS];
  logic [TOT_W-1:0] total_r;

  always_comb begin
    for (int a = 0; a < NUM_AREAS; a++) begin
      if (a < ssa_pkg::CFG_AREAS) begin
        if (32'(cfg_slots_r[a]) > 32'(SLOTS_PER_AREA)) begin
          usable[a] = CNT_W'(SLOTS_PER_AREA);
        end else begin
          usable[a] = CNT_W'(cfg_slots_r[a]);
        end
        tagv[a] = cfg_tag_r[a];
      end else begin
        usable[a] = '0;
        tagv[a]   = TW'(a);
      end
    end
  end

  // Area selection on accept
  logic [ARW-1:0] a_sel, f_sel, sel;
  logic           a_found, f_match, f_range, found;
  logic [IW-1:0]  base, start;
  logic [IW:0]    endx;

  always_comb begin
    a_sel   = '0;
    a_found = 1'b0;
    f_sel   = '0;
    f_match = 1'b0;
    for (int a = NUM_AREAS - 1; a >= 0; a--) begin
      if (cnt_r[a] < usable[a]) begin
        a_sel   = ARW'(a);
        a_found = 1'b1;
      end
      if (tagv[a] == in_tag) begin
        f_sel   = ARW'(a);
        f_match = 1'b1;
      end
    end
    f_range = 32'(in_offset) < 32'(usable[f_sel]);
    sel     = (in_action == ssa_pkg::ACT_FREE) ? f_sel : a_sel;
    found   = (in_action == ssa_pkg::ACT_FREE) ? (f_match && f_range) : a_found;
    base    = IW'(sel) * IW'(SLOTS_PER_AREA);
    start   = (in_action == ssa_pkg::ACT_FREE) ? base + IW'(in_offset) : base;
    endx    = (IW + 1)'(base) + (IW + 1)'(usable[sel]);
  end

  logic           act_r, found_r;
  logic [ARW-1:0] area_r;
  logic [AW-1:0]  addr_r, wf_r;
  logic [AW:0]    we_r;
  logic [BW-1:0]  bit_r, lo_r, hi_r;
  logic [IW-1:0]  base_r;

  // Latch request and search bounds
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r   <= in_action;
      found_r <= found;
      area_r  <= sel;
      base_r  <= base;
      addr_r  <= start[IW-1:BW];
      bit_r   <= start[BW-1:0];
      wf_r    <= base[IW-1:BW];
      lo_r    <= base[BW-1:0];
      we_r    <= endx[IW:BW];
      hi_r    <= endx[BW-1:0];
    end else if (cmd.step) begin
      addr_r <= addr_r + AW'(1);
    end
  end

  // Bitmap memory, one word per row, registered read
  logic [WB-1:0] mem [MEM_D];
  logic [WB-1:0] rdata_r;
  logic [AW-1:0] clr_addr_r;
  logic [WB-1:0] wdata;
  logic [AW-1:0] rd_addr;

  assign rd_addr = cmd.step ? addr_r + AW'(1) : addr_r;

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      mem[clr_addr_r] <= '0;
    end else if (cmd.commit) begin
      mem[addr_r] <= wdata;
    end
    if (cmd.rd || cmd.step) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Clearing pass address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  // Word check: lowest free bit inside the area, or the addressed bit on free
  logic [WB-1:0] vmask, freev;
  logic [BW-1:0] pick, sel_bit;
  logic          hit;

  always_comb begin
    pick = '0;
    for (int b = 0; b < WB; b++) begin
      vmask[b] = ((addr_r != wf_r) || (BW'(b) >= lo_r)) &&
                 (({1'b0, addr_r} != we_r) || (BW'(b) < hi_r));
    end
    freev = ~rdata_r & vmask;
    for (int b = WB - 1; b >= 0; b--) begin
      if (freev[b]) pick = BW'(b);
    end
    sel_bit = (act_r == ssa_pkg::ACT_FREE) ? bit_r : pick;
    hit     = (act_r == ssa_pkg::ACT_FREE) ? rdata_r[bit_r] : |freev;
    wdata   = rdata_r ^ (WB'(1) << sel_bit);
  end

  // Area and total counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NUM_AREAS; a++) cnt_r[a] <= '0;
      total_r <= '0;
    end else if (cmd.commit) begin
      if (act_r == ssa_pkg::ACT_FREE) begin
        if (cnt_r[area_r] != '0) cnt_r[area_r] <= cnt_r[area_r] - CNT_W'(1);
        if (total_r != '0)       total_r <= total_r - TOT_W'(1);
      end else begin
        cnt_r[area_r] <= cnt_r[area_r] + CNT_W'(1);
        total_r       <= total_r + TOT_W'(1);
      end
    end
  end

  // Result fields
  ssa_pkg::status_t             res_st_r;
  logic [TW-1:0]                res_tag_r;
  logic [ssa_pkg::OFF_OUT_W-1:0] res_off_r;
  logic [IW-1:0]                flat_off;

  assign flat_off = {addr_r, pick} - base_r;

  always_ff @(posedge clk) begin
    if (cmd.reject) begin
      res_st_r  <= (act_r == ssa_pkg::ACT_FREE) ? ssa_pkg::ST_NOT_FOUND
                                                : ssa_pkg::ST_NO_SPACE;
      res_tag_r <= '0;
      res_off_r <= '0;
    end else if (cmd.free_miss) begin
      res_st_r  <= ssa_pkg::ST_ALREADY_FREE;
      res_tag_r <= '0;
      res_off_r <= '0;
    end else if (cmd.commit) begin
      res_st_r <= ssa_pkg::ST_OK;
      if (act_r == ssa_pkg::ACT_FREE) begin
        res_tag_r <= '0;
        res_off_r <= '0;
      end else begin
        res_tag_r <= tagv[area_r];
        res_off_r <= ssa_pkg::OFF_OUT_W'(flat_off);
      end
    end
  end

  // Output register
  logic                          out_valid_r;
  logic [ssa_pkg::OUT_DATA_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= {7'd0, ssa_pkg::TOTAL_OUT_W'(total_r), res_off_r, res_tag_r, res_st_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Status to controller
  always_comb begin
    sts.clr_last = (32'(clr_addr_r) == NWORDS - 1);
    sts.is_free  = (act_r == ssa_pkg::ACT_FREE);
    sts.found    = found_r;
    sts.hit      = hit;
    sts.out_free = !out_valid_r || out_tready;
  end

endmodule

### design/swap_slot_allocator_unit.sv
// Channel | dir | handshake           | payload
// in_     | in  | in_tvalid/in_tready | tuser: action; tdata: entry_tag, entry_offset
// out_    | out | out_tvalid/out_tready | tdata: status, slot_tag, slot_offset, total_used
// cfg_    | in  | cfg_we              | cfg_index, cfg_wdata
// Rejected word (no room, no tag match, offset out of range): accept, plan, output load.
// Free: accept, plan, bitmap read and write-back, output load.
// Allocate: accept, plan, then a scan of the 16-bit bitmap words of the chosen
// area, one word per cycle (at most ceil(slots/16) + 1 words), then output load.
// After reset a clearing pass zeroes all ceil(NUM_AREAS*SLOTS_PER_AREA/16) bitmap words
// before the first word is taken. A stalled output holds the next result.
// Top level; depends on ssa_pkg, ssa_ctrl and ssa_dpath.
module swap_slot_allocator_unit #(
  parameter int NUM_AREAS      = 4,
  parameter int SLOTS_PER_AREA = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [ssa_pkg::IN_DATA_W-1:0]       in_tdata,  // entry_tag, entry_offset
  input  logic                                in_tuser,  // action
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ssa_pkg::OUT_DATA_W-1:0]      out_tdata, // status, slot_tag, slot_offset, total_used
  input  logic                                cfg_we,
  input  logic [ssa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ssa_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  ssa_pkg::cmd_t cmd;
  ssa_pkg::sts_t sts;

  ssa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ssa_dpath #(
    .NUM_AREAS      (NUM_AREAS),
    .SLOTS_PER_AREA (SLOTS_PER_AREA)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_action  (in_tuser),
    .in_tag     (in_tdata[7:0]),
    .in_offset  (in_tdata[31:8]),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### design/ssa_checker.sv
// Port checker of the swap slot allocator, bound to the top level.
// Depends on assert_macros.svh and ssa_pkg.
`include "assert_macros.svh"

module ssa_checker #(
  parameter int NUM_AREAS      = 4,
  parameter int SLOTS_PER_AREA = 1024
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [ssa_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam logic [12:0] MAX_TOTAL = 13'(NUM_AREAS * SLOTS_PER_AREA);

  // A stalled result word holds
  `SSA_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result word changed while stalled")

  // One item at a time: no accept right after an accept
  `SSA_ASSERT(a_one_item, in_tvalid && in_tready |=> !in_tready, "input accepted back to back")

  // Failed results (status other than OK) carry no slot
  `SSA_ASSERT(a_no_slot, out_tvalid && (out_tdata[1:0] != ssa_pkg::ST_OK) |-> out_tdata[19:2] == 18'd0, "slot fields set on failure")

  // Used total stays within capacity
  `SSA_ASSERT(a_total, out_tvalid |-> out_tdata[32:20] <= MAX_TOTAL, "total above capacity")

  // No input taken during reset
  `SSA_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !in_tready && !out_tvalid, "active straight after reset")

endmodule

bind swap_slot_allocator_unit ssa_checker #(
  .NUM_AREAS      (NUM_AREAS),
  .SLOTS_PER_AREA (SLOTS_PER_AREA)
) u_ssa_checker (.*);

### tb/tb.sv
// Self-checking bench for swap_slot_allocator_unit: directed and random
// allocate/free words, with its own first-fit prediction. Needs ssa_pkg.
`timescale 1ns / 1ps

module tb;

  localparam int AREAS      = 4;
  localparam int AREA_SLOTS = 1024;
  localparam int CYCLE_CAP  = 1000000;
  localparam int SETTLE     = 100;
  localparam int HOLD_LEN   = 400;
  localparam int PHASE_LEN  = 150;

  // Register indexes
  localparam logic [ssa_pkg::CFG_IDX_W-1:0] REG_SLOTS0 = 3'd0;
  localparam logic [ssa_pkg::CFG_IDX_W-1:0] REG_TAG0   = 3'd4;

  typedef struct {
    logic                           action;
    logic [ssa_pkg::TAG_W-1:0]      tag;
    logic [ssa_pkg::OFF_IN_W-1:0]   offset;
  } request_t;

  typedef struct {
    ssa_pkg::status_t                  status;
    logic [ssa_pkg::TAG_W-1:0]         tag;
    logic [ssa_pkg::OFF_OUT_W-1:0]     offset;
    logic [ssa_pkg::TOTAL_OUT_W-1:0]   total;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [ssa_pkg::IN_DATA_W-1:0] in_tdata = '0;  // entry_tag, entry_offset
  logic in_tuser = 1'b0;                         // action
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [ssa_pkg::OUT_DATA_W-1:0] out_tdata;     // status, slot_tag, slot_offset, total_used
  logic cfg_we = 1'b0;
  logic [ssa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ssa_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  swap_slot_allocator_unit #(.NUM_AREAS(AREAS), .SLOTS_PER_AREA(AREA_SLOTS)) dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted allocator state
  bit                             slot_map [AREAS][AREA_SLOTS];
  int unsigned                    area_count [AREAS];
  int unsigned                    total_count;
  logic [ssa_pkg::CFG_DATA_W-1:0] area_slots [AREAS];
  logic [ssa_pkg::TAG_W-1:0]      area_tag [AREAS];

  request_t words_to_send [$];
  reply_t   replies_due [$];
  request_t on_bus;
  int send_idle = 32, recv_idle = 70;
  int mismatches = 0, replies_seen = 0, words_sent = 0;
  int cycles = 0;
  logic hold_req = 1'b0;
  int hold_cnt = 0;

  function automatic int unsigned usable(int a);
    return (area_slots[a] > AREA_SLOTS) ? AREA_SLOTS : area_slots[a];
  endfunction

  // First-fit allocate or free against the predicted bitmap
  function automatic reply_t allocate_or_free(request_t r);
    reply_t rep;
    int unsigned n;
    bit done;
    rep.status = ssa_pkg::ST_NO_SPACE;
    rep.tag = '0;
    rep.offset = '0;
    done = 0;
    if (r.action == ssa_pkg::ACT_ALLOC) begin
      for (int a = 0; a < AREAS && !done; a++) begin
        n = usable(a);
        if (area_count[a] >= n) continue;
        for (int s = 0; s < n; s++) begin
          if (!slot_map[a][s]) begin
            slot_map[a][s] = 1;
            area_count[a]++;
            total_count++;
            rep.status = ssa_pkg::ST_OK;
            rep.tag = area_tag[a];
            rep.offset = s[ssa_pkg::OFF_OUT_W-1:0];
            done = 1;
            break;
          end
        end
      end
    end else begin
      rep.status = ssa_pkg::ST_NOT_FOUND;
      for (int a = 0; a < AREAS; a++) begin
        if (area_tag[a] != r.tag) continue;
        if (r.offset < usable(a)) begin
          if (slot_map[a][r.offset]) begin
            slot_map[a][r.offset] = 0;
            if (area_count[a] > 0) area_count[a]--;
            if (total_count > 0) total_count--;
            rep.status = ssa_pkg::ST_OK;
          end else begin
            rep.status = ssa_pkg::ST_ALREADY_FREE;
          end
        end
        break;
      end
    end
    rep.total = total_count[ssa_pkg::TOTAL_OUT_W-1:0];
    return rep;
  endfunction

  // Driver: predict on acceptance, then offer the next word
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        replies_due.push_back(allocate_or_free(on_bus));
        words_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (words_to_send.size() > 0 && $urandom_range(99) >= send_idle) begin
          on_bus = words_to_send.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= on_bus.action;
          in_tdata <= {on_bus.offset, on_bus.tag};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure, one long hold-off when asked
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_req && hold_cnt < HOLD_LEN) begin
      hold_cnt <= hold_cnt + 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Monitor: compare each accepted word with the oldest prediction
  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      replies_seen++;
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", out_tdata);
      end else begin
        want = replies_due.pop_front();
        if (out_tdata[1:0] !== want.status || out_tdata[9:2] !== want.tag ||
            out_tdata[19:10] !== want.offset || out_tdata[32:20] !== want.total ||
            out_tdata[39:33] !== '0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want st=%0d tag=%h off=%0d tot=%0d, %s%0d %s%h %s%0d %s%0d",
                     want.status, want.tag, want.offset, want.total,
                     "got st=", out_tdata[1:0], "tag=", out_tdata[9:2],
                     "off=", out_tdata[19:10], "tot=", out_tdata[32:20]);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (words_to_send.size() != 0 || in_tvalid || replies_due.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(int idx, int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx[ssa_pkg::CFG_IDX_W-1:0];
    cfg_wdata <= value[ssa_pkg::CFG_DATA_W-1:0];
    if (idx < ssa_pkg::CFG_AREAS) area_slots[idx] = value[ssa_pkg::CFG_DATA_W-1:0];
    else area_tag[idx - ssa_pkg::CFG_AREAS] = value[ssa_pkg::TAG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_areas(int s0, int s1, int s2, int s3, int t0, int t1, int t2, int t3);
    write_reg(REG_SLOTS0 + 0, s0);
    write_reg(REG_SLOTS0 + 1, s1);
    write_reg(REG_SLOTS0 + 2, s2);
    write_reg(REG_SLOTS0 + 3, s3);
    write_reg(REG_TAG0 + 0, t0);
    write_reg(REG_TAG0 + 1, t1);
    write_reg(REG_TAG0 + 2, t2);
    write_reg(REG_TAG0 + 3, t3);
  endtask

  task automatic queue_word(logic act, int tag, int off);
    request_t r;
    r.action = act;
    r.tag = tag[ssa_pkg::TAG_W-1:0];
    r.offset = off[ssa_pkg::OFF_IN_W-1:0];
    words_to_send.push_back(r);
  endtask

  function automatic int pick_slots();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 0;
    if (r < 18) return 2047;
    if (r < 23) return 1024;
    return $urandom_range(1, 40);
  endfunction

  function automatic int pick_tag();
    return ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(3);
  endfunction

  initial begin
    for (int a = 0; a < AREAS; a++) begin
      area_slots[a] = '0;
      area_tag[a] = a[ssa_pkg::TAG_W-1:0];
      area_count[a] = 0;
      for (int s = 0; s < AREA_SLOTS; s++) slot_map[a][s] = 0;
    end
    total_count = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty area skipped, clamped size, shared tag, zero entry
    set_areas(3, 0, 2, 2047, 0, 255, 0, 5);
    repeat (6) queue_word(ssa_pkg::ACT_ALLOC, 255, 24'hFFFFFF);
    queue_word(ssa_pkg::ACT_FREE, 0, 0);
    queue_word(ssa_pkg::ACT_FREE, 0, 0);
    queue_word(ssa_pkg::ACT_FREE, 0, 3);
    queue_word(ssa_pkg::ACT_FREE, 255, 0);
    queue_word(ssa_pkg::ACT_FREE, 7, 0);
    queue_word(ssa_pkg::ACT_FREE, 5, 24'hFFFFFF);
    queue_word(ssa_pkg::ACT_FREE, 5, 0);
    queue_word(ssa_pkg::ACT_ALLOC, 0, 0);
    wait_idle();

    // Directed: size lowered below use, then no room anywhere
    set_areas(1, 0, 0, 0, 0, 1, 2, 3);
    queue_word(ssa_pkg::ACT_ALLOC, 0, 0);
    queue_word(ssa_pkg::ACT_FREE, 0, 1);
    queue_word(ssa_pkg::ACT_FREE, 0, 0);
    queue_word(ssa_pkg::ACT_ALLOC, 0, 0);
    queue_word(ssa_pkg::ACT_FREE, 1, 0);
    wait_idle();

    // Random phases with shifting idle pattern
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        send_idle = 70; recv_idle = 32;
      end else if (ph == 4) begin
        send_idle = 0; recv_idle = 0;
      end
      if (ph == 5) set_areas(1024, 1024, 1024, 1024, 255, 255, 0, 0);
      else set_areas(pick_slots(), pick_slots(), pick_slots(), pick_slots(),
                     pick_tag(), pick_tag(), pick_tag(), pick_tag());
      if (ph == 3) hold_req <= 1'b1;
      for (int i = 0; i < PHASE_LEN; i++) begin
        if ($urandom_range(99) < 55)
          queue_word(ssa_pkg::ACT_ALLOC, $urandom_range(255), $urandom_range(24'hFFFFFF));
        else
          queue_word(ssa_pkg::ACT_FREE,
                     ($urandom_range(4) != 0) ? area_tag[$urandom_range(AREAS - 1)]
                                              : $urandom_range(255),
                     ($urandom_range(4) != 0) ? $urandom_range(47)
                                              : $urandom_range(24'hFFFFFF));
      end
      wait_idle();
    end

    $display("covered %0d request words and %0d result words over 8 area settings",
             words_sent, replies_seen);
    $display("final slots in use: %0d, mismatches: %0d", total_count, mismatches);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
